>>> src/rgb_channel_histogram_macros.svh
// Assertion helpers, all sampled on clk and disabled in reset.
`ifndef RGB_CHANNEL_HISTOGRAM_MACROS_SVH
`define RGB_CHANNEL_HISTOGRAM_MACROS_SVH

// Same-cycle implication.
`define RCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rch_pkg.sv
package rch_pkg;

  localparam int BIN_IDX_W = 6;
  localparam int BC_W      = 7;
  localparam int MV_W      = 16;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [BC_W-1:0] BIN_COUNT_RST = 7'd64;
  localparam logic [MV_W-1:0] MAX_VALUE_RST = 16'd255;

  typedef enum logic {
    REG_BIN_COUNT = 1'b0,
    REG_MAX_VALUE = 1'b1
  } rch_reg_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic count_en;
    logic shift_en;
    logic clear;
  } rch_cell_ctl_t;

  // Status of the front pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic last_busy;
  } rch_pipe_sts_t;

endpackage

>>> src/rch_pix_if.sv
interface rch_pix_if #(
  parameter int CH_W = 16
) ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

>>> src/rch_bin_if.sv
interface rch_bin_if
  import rch_pkg::*;
#(
  parameter int CNT_W = 24
) ();
  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [CNT_W-1:0]     bin_total;
  logic                 last_bin;

  modport source (output valid, bin_index, bin_total, last_bin, input ready);
  modport sink   (input valid, bin_index, bin_total, last_bin, output ready);
endinterface

>>> src/rch_prod.sv
// Input register, then (v+1)*n per channel. A cell compares that
// product against k*max_value, which is v >= floor(k*max_value/n).
module rch_prod
  import rch_pkg::*;
#(
  parameter int CH_W = 16,
  parameter int NB_W = 7,
  parameter int KM_W = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic [CH_W-1:0]           red,
  input  logic [CH_W-1:0]           green,
  input  logic [CH_W-1:0]           blue,
  input  logic                      last_pixel,
  input  logic [NB_W-1:0]           n,
  output logic [2:0][KM_W-1:0]      prod,
  output rch_pipe_sts_t             sts
);

  localparam int PR_W = CH_W + 1 + NB_W;

  logic [2:0][CH_W-1:0] v_r;
  logic                 s1_valid_r;
  logic                 s1_last_r;
  logic [2:0][KM_W-1:0] prod_r;
  logic                 s2_valid_r;
  logic                 s2_last_r;
  logic [2:0][PR_W-1:0] prod_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = PR_W'({1'b0, v_r[c]} + (CH_W+1)'(1)) * PR_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      s1_last_r  <= acc && last_pixel;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_valid_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      v_r[0] <= red;
      v_r[1] <= green;
      v_r[2] <= blue;
    end
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= KM_W'(prod_nxt[c]);
    end
  end

  assign prod          = prod_r;
  assign sts.valid     = s2_valid_r;
  assign sts.last      = s2_valid_r && s2_last_r;
  assign sts.last_busy = (s1_valid_r && s1_last_r) || (s2_valid_r && s2_last_r);

endmodule

>>> src/rch_cell.sv
// One histogram bin: its threshold product k*max_value, passed down the
// row, and its saturating counter, which also shifts toward bin 0 on readout.
module rch_cell
  import rch_pkg::*;
#(
  parameter int KM_W    = 24,
  parameter int CNT_W   = 24,
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rch_cell_ctl_t        ctl,
  input  logic [2:0][KM_W-1:0] prod,
  input  logic [KM_W-1:0]      max_value,
  input  logic [KM_W-1:0]      km_prev,
  input  logic                 in_use,
  input  logic [2:0]           ge_next,
  input  logic [CNT_W-1:0]     cnt_next,
  output logic [KM_W-1:0]      km,
  output logic [2:0]           ge,
  output logic [CNT_W-1:0]     cnt
);

  logic [KM_W-1:0]  km_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [2:0]       hit;
  logic [1:0]       hits;
  logic [CNT_W:0]   sum;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ge[c]  = in_use && (prod[c] > km_r);
      hit[c] = ge[c] && !ge_next[c];
    end
    hits = 2'(hit[0]) + 2'(hit[1]) + 2'(hit[2]);
    sum  = {1'b0, cnt_r} + (CNT_W+1)'(hits);
    priority if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (ctl.shift_en) begin
      cnt_nxt = cnt_next;
    end else if (ctl.count_en) begin
      cnt_nxt = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    km_r <= IS_HEAD ? '0 : km_prev + max_value;
  end

  assign km  = km_r;
  assign cnt = cnt_r;

endmodule

>>> src/rgb_channel_histogram.sv
// Pixels are taken one per clock while in_pix.ready is high, and each passes the input
// and product registers before it is counted. After the last pixel of an image, bins
// 0..n-1 leave one per cycle while out_bin.ready is high, and input stalls until the
// final bin is taken. Bin thresholds ripple down the row of MAX_BINS cells one cell per
// cycle, so reset and every register write hold input off while a settle counter runs down.
// Reset (synchronous, rst_n low) clears all counters, bin_count=64, max_value=255.
module rgb_channel_histogram
  import rch_pkg::*;
#(
  parameter int MAX_BINS     = 64,
  parameter int COUNT_BITS   = 24,
  parameter int CHANNEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  rch_pix_if.sink            in_pix,
  rch_bin_if.source          out_bin,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

`include "rgb_channel_histogram_macros.svh"

  localparam int NB_W = $clog2(MAX_BINS + 1);
  localparam int KM_W = MV_W + 1 + NB_W;

  typedef enum logic {
    ST_RUN,
    ST_DUMP
  } state_t;

  state_t            state_r, state_nxt;
  logic [NB_W-1:0]   idx_r, idx_nxt;
  logic [BC_W-1:0]   bin_count_r;
  logic [MV_W-1:0]   max_value_r;
  logic [NB_W-1:0]   settle_r;
  logic [NB_W-1:0]   n;
  logic              cfg_wr;
  rch_reg_t          cfg_reg;
  logic              in_acc;
  logic              out_hs;
  logic              dump_end;
  rch_cell_ctl_t     ctl;
  rch_pipe_sts_t     sts;
  logic [2:0][KM_W-1:0] prod;
  logic [KM_W-1:0]      km_w  [MAX_BINS];
  logic [2:0]           ge_w  [MAX_BINS];
  logic [COUNT_BITS-1:0] cnt_w [MAX_BINS];

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_reg    = rch_reg_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_reg)
      REG_BIN_COUNT: cfg_prdata = APB_DW'(bin_count_r);
      REG_MAX_VALUE: cfg_prdata = APB_DW'(max_value_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= BIN_COUNT_RST;
      max_value_r <= MAX_VALUE_RST;
      settle_r    <= NB_W'(MAX_BINS);
    end else begin
      if (cfg_wr) begin
        settle_r <= NB_W'(MAX_BINS);
        unique case (cfg_reg)
          REG_BIN_COUNT: bin_count_r <= cfg_pwdata[BC_W-1:0];
          REG_MAX_VALUE: max_value_r <= cfg_pwdata[MV_W-1:0];
          default: ;
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - NB_W'(1);
      end
    end
  end

  // Effective bin count: zero reads as one, clipped at MAX_BINS.
  always_comb begin
    priority if (bin_count_r == '0) begin
      n = NB_W'(1);
    end else if (BC_W'(bin_count_r) > BC_W'(MAX_BINS)) begin
      n = NB_W'(MAX_BINS);
    end else begin
      n = NB_W'(bin_count_r);
    end
  end

  // Input side
  assign in_pix.ready = (state_r == ST_RUN) && (settle_r == '0) && !sts.last_busy;
  assign in_acc       = in_pix.valid && in_pix.ready;

  rch_prod #(
    .CH_W (CHANNEL_BITS),
    .NB_W (NB_W),
    .KM_W (KM_W)
  ) u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .red        (in_pix.red),
    .green      (in_pix.green),
    .blue       (in_pix.blue),
    .last_pixel (in_pix.last_pixel),
    .n          (n),
    .prod       (prod),
    .sts        (sts)
  );

  // Row of bin cells
  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    logic [KM_W-1:0]       km_prev;
    logic [2:0]            ge_next;
    logic [COUNT_BITS-1:0] cnt_next;

    if (k == 0) begin : g_head
      assign km_prev = '0;
    end else begin : g_body
      assign km_prev = km_w[k-1];
    end

    if (k == MAX_BINS - 1) begin : g_tail
      assign ge_next  = '0;
      assign cnt_next = '0;
    end else begin : g_link
      assign ge_next  = ge_w[k+1];
      assign cnt_next = cnt_w[k+1];
    end

    rch_cell #(
      .KM_W    (KM_W),
      .CNT_W   (COUNT_BITS),
      .IS_HEAD (k == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prod      (prod),
      .max_value (KM_W'(max_value_r)),
      .km_prev   (km_prev),
      .in_use    (NB_W'(k) < n),
      .ge_next   (ge_next),
      .cnt_next  (cnt_next),
      .km        (km_w[k]),
      .ge        (ge_w[k]),
      .cnt       (cnt_w[k])
    );
  end

  // Readout sequencer: the head cell always holds the bin being offered, as counts shift toward it.
  assign out_hs   = out_bin.valid && out_bin.ready;
  assign dump_end = out_hs && (idx_r == n - NB_W'(1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_RUN: begin
        if (sts.last) begin
          state_nxt = ST_DUMP;
          idx_nxt   = '0;
        end
      end
      ST_DUMP: begin
        if (dump_end) begin
          state_nxt = ST_RUN;
          idx_nxt   = '0;
        end else if (out_hs) begin
          idx_nxt = idx_r + NB_W'(1);
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign ctl.count_en = sts.valid;
  assign ctl.shift_en = out_hs && !dump_end;
  assign ctl.clear    = dump_end;

  assign out_bin.valid     = (state_r == ST_DUMP);
  assign out_bin.bin_index = BIN_IDX_W'(idx_r);
  assign out_bin.bin_total = cnt_w[0];
  assign out_bin.last_bin  = (idx_r == n - NB_W'(1));

  `RCH_ASSERT_NOW(a_no_in_during_dump, out_bin.valid, !in_pix.ready, "input open during readout")
  `RCH_ASSERT_NEXT(a_last_starts_dump, sts.last, state_r == ST_DUMP, "last pixel did not start readout")
  `RCH_ASSERT_NEXT(a_dump_clears, dump_end, cnt_w[0] == '0 && state_r == ST_RUN, "counters not cleared")
  `RCH_ASSERT_NEXT(a_cfg_holds_input, cfg_wr, !in_pix.ready, "input open while thresholds settle")
  `RCH_ASSERT_NOW(a_idx_in_range, state_r == ST_DUMP, idx_r < n, "bin index beyond bin count")

endmodule
